// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the image upscaler.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/ius_pkg.sv -----
// Types, constants and the pixel averaging function of the image upscaler.
// No dependencies.
`default_nettype none

package ius_pkg;

   localparam int unsigned CH_BITS       = 8;
   localparam int unsigned PIX_BITS      = 3 * CH_BITS;
   localparam int unsigned ROW_BITS      = 12;
   localparam int unsigned OUT_ROW_BITS  = 13;
   localparam int unsigned OUT_COL_BITS  = 11;
   localparam int unsigned IMG_W_BITS    = 11;
   localparam int unsigned IMG_H_BITS    = 13;
   localparam int unsigned CSR_DATA_BITS = 13;
   localparam int unsigned DEF_MAX_WIDTH = 1024;

   localparam logic [IMG_H_BITS-1:0] MAX_HEIGHT = IMG_H_BITS'(4096);

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [PIX_BITS-1:0] rgb_type;

   // beat mask order: centre, vertical, horizontal, original
   typedef struct packed {
      logic [3:0]              mask;
      rgb_type                 cen;
      rgb_type                 ver;
      rgb_type                 hor;
      rgb_type                 org;
      logic [OUT_ROW_BITS-1:0] row;
      logic [OUT_COL_BITS-1:0] col;
   } ius_beats_type;

   // truncated per-channel mean
   function automatic rgb_type avg_px(input rgb_type a, input rgb_type b);
      logic [CH_BITS:0] s;
      rgb_type          res;
      res = '0;
      for (int i = 0; i < 3; i++) begin
         s = {1'b0, a[i*CH_BITS +: CH_BITS]} + {1'b0, b[i*CH_BITS +: CH_BITS]};
         res[i*CH_BITS +: CH_BITS] = s[CH_BITS:1];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/image_upscale_2x_minus_one_interp.sv -----
// 2x image upscaler with midpoint interpolation, (2W-1) x (2H-1) output.
// A pixel is registered in stage 1 and then in the output stage before its first
// beat is valid; each pixel gives 1, 2 or 4 beats on the single output channel,
// which can hold the input; the line buffer RAM does one read and one write per pixel.
// Reset clears counters, neighbour registers and config (width 1, height 1);
// the line buffer is not cleared.
`default_nettype none

module image_upscale_2x_minus_one_interp #(
   parameter int unsigned MAX_WIDTH = ius_pkg::DEF_MAX_WIDTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [ius_pkg::CH_BITS-1:0]      req_red_in,
   input  wire logic [ius_pkg::CH_BITS-1:0]      req_green_in,
   input  wire logic [ius_pkg::CH_BITS-1:0]      req_blue_in,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [ius_pkg::CH_BITS-1:0]           rsp_red_out,
   output logic [ius_pkg::CH_BITS-1:0]           rsp_green_out,
   output logic [ius_pkg::CH_BITS-1:0]           rsp_blue_out,
   output logic [ius_pkg::OUT_ROW_BITS-1:0]      rsp_out_row,
   output logic [ius_pkg::OUT_COL_BITS-1:0]      rsp_out_col,
   output logic                                  rsp_run_last,
   input  wire logic                             csr_wr_en,
   input  wire ius_pkg::csr_index_type           csr_index,
   input  wire logic [ius_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import ius_pkg::*;

   `include "assert_macros.svh"

   localparam int unsigned CW = $clog2(MAX_WIDTH);
   localparam int unsigned WW = (CW + 1 > IMG_W_BITS) ? CW + 1 : IMG_W_BITS;

   // configuration
   logic [IMG_W_BITS-1:0] image_width_ff;
   logic [IMG_H_BITS-1:0] image_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMG_W_BITS'(1);
         image_height_ff <= IMG_H_BITS'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata[IMG_W_BITS-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wdata[IMG_H_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // effective limits
   logic [WW-1:0]         width_ext, width_eff, col_inc;
   logic [IMG_H_BITS-1:0] height_eff, row_inc;

   always_comb begin
      width_ext = WW'(image_width_ff);
      if (width_ext == '0) begin
         width_eff = WW'(1);
      end else if (width_ext > WW'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      if (image_height_ff == '0) begin
         height_eff = IMG_H_BITS'(1);
      end else if (image_height_ff > MAX_HEIGHT) begin
         height_eff = MAX_HEIGHT;
      end else begin
         height_eff = image_height_ff;
      end
   end

   // position counters and input stage
   logic [CW-1:0]       col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic                accept, s1_move, emit_free;

   logic                s1_valid_ff, s1_valid_in;
   rgb_type             s1_px_ff;
   logic [CW-1:0]       s1_col_ff;
   logic [ROW_BITS-1:0] s1_row_ff;
   logic                s1_fwd_ff;
   rgb_type             s1_fwd_data_ff;

   assign s1_move   = s1_valid_ff && emit_free;
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   assign col_inc = WW'(col_ff) + WW'(1);
   assign row_inc = IMG_H_BITS'(row_ff) + IMG_H_BITS'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_inc >= width_eff) begin
            col_in = '0;
            row_in = (row_inc >= height_eff) ? '0 : row_inc[ROW_BITS-1:0];
         end else begin
            col_in = col_inc[CW-1:0];
         end
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !s1_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // line buffer: read on accept, write back when the pixel leaves stage 1
   logic    ram_wr_en;
   rgb_type ram_rd_data;

   assign ram_wr_en = s1_move;

   ius_ram #(
      .WIDTH (PIX_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (s1_px_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // same-entry write in the read cycle: keep the new data
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff       <= {req_red_in, req_green_in, req_blue_in};
         s1_col_ff      <= col_ff;
         s1_row_ff      <= row_ff;
         s1_fwd_ff      <= ram_wr_en && (s1_col_ff == col_ff);
         s1_fwd_data_ff <= s1_px_ff;
      end
   end

   // neighbour registers and beat set
   rgb_type       left_cur_ff, left_above_ff, above;
   logic          r_pos, c_pos;
   ius_beats_type beats;

   assign above = s1_fwd_ff ? s1_fwd_data_ff : ram_rd_data;
   assign r_pos = s1_row_ff != '0;
   assign c_pos = s1_col_ff != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_cur_ff   <= '0;
         left_above_ff <= '0;
      end else if (s1_move) begin
         left_cur_ff   <= s1_px_ff;
         left_above_ff <= above;
      end
   end

   always_comb begin
      beats.mask = {1'b1, c_pos, r_pos, r_pos && c_pos};
      beats.cen  = avg_px(avg_px(left_above_ff, above), avg_px(left_cur_ff, s1_px_ff));
      beats.ver  = avg_px(above, s1_px_ff);
      beats.hor  = avg_px(left_cur_ff, s1_px_ff);
      beats.org  = s1_px_ff;
      beats.row  = {s1_row_ff, 1'b0};
      beats.col  = OUT_COL_BITS'({s1_col_ff, 1'b0});
   end

   ius_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .load          (s1_move),
      .beats         (beats),
      .free          (emit_free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_run_last  (rsp_run_last)
   );

   // closing beat of a pixel is always the original at even coordinates
   `ASSERT_IMPLIES(a_last_is_orig, clock, reset, rsp_valid && rsp_run_last,
      !rsp_out_row[0] && !rsp_out_col[0])
   // interpolated beats sit on an odd row or column
   `ASSERT_IMPLIES(a_interp_odd, clock, reset, rsp_valid && !rsp_run_last,
      rsp_out_row[0] || rsp_out_col[0])
   // a pixel handed to the output stage shows up next cycle
   `ASSERT_NEXT(a_move_shows, clock, reset, s1_move, rsp_valid)

endmodule

`default_nettype wire

// ----- hw/rtl/ius_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ius_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  wire logic [WIDTH-1:0]                wr_data,
   input  wire logic                            rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]        rd_addr,
   output logic      [WIDTH-1:0]                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ius_emit.sv -----
// Output stage: holds the beats caused by one pixel and sends them in order.
// Depends on ius_pkg.
`default_nettype none

module ius_emit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           load,
   input  wire ius_pkg::ius_beats_type         beats,
   output logic                                free,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [ius_pkg::CH_BITS-1:0]         rsp_red_out,
   output logic [ius_pkg::CH_BITS-1:0]         rsp_green_out,
   output logic [ius_pkg::CH_BITS-1:0]         rsp_blue_out,
   output logic [ius_pkg::OUT_ROW_BITS-1:0]    rsp_out_row,
   output logic [ius_pkg::OUT_COL_BITS-1:0]    rsp_out_col,
   output logic                                rsp_run_last
);
   import ius_pkg::*;

   logic [3:0]    mask_ff, mask_in;
   ius_beats_type beats_ff;
   logic          single;
   rgb_type       px;

   assign single       = (mask_ff & (mask_ff - 4'd1)) == 4'd0;
   assign rsp_valid    = mask_ff != 4'd0;
   assign rsp_run_last = rsp_valid && single;
   assign free         = !rsp_valid || (rsp_ready && single);

   always_comb begin
      mask_in = mask_ff;
      if (load) begin
         mask_in = beats.mask;
      end else if (rsp_valid && rsp_ready) begin
         mask_in = mask_ff & (mask_ff - 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beats_ff <= beats;
      end
   end

   // lowest pending beat goes first
   always_comb begin
      if (mask_ff[0]) begin
         px          = beats_ff.cen;
         rsp_out_row = beats_ff.row - OUT_ROW_BITS'(1);
         rsp_out_col = beats_ff.col - OUT_COL_BITS'(1);
      end else if (mask_ff[1]) begin
         px          = beats_ff.ver;
         rsp_out_row = beats_ff.row - OUT_ROW_BITS'(1);
         rsp_out_col = beats_ff.col;
      end else if (mask_ff[2]) begin
         px          = beats_ff.hor;
         rsp_out_row = beats_ff.row;
         rsp_out_col = beats_ff.col - OUT_COL_BITS'(1);
      end else begin
         px          = beats_ff.org;
         rsp_out_row = beats_ff.row;
         rsp_out_col = beats_ff.col;
      end
   end

   assign rsp_red_out   = px[2*CH_BITS +: CH_BITS];
   assign rsp_green_out = px[CH_BITS +: CH_BITS];
   assign rsp_blue_out  = px[0 +: CH_BITS];

endmodule

`default_nettype wire
